// File: src/pic_pkg.sv
// Shared types and constants for the platform interrupt controller.
// Used by pic_ctrl, pic_dp and the top level; depends on nothing.
package pic_pkg;

	localparam int NumCtx    = 2;
	localparam int SrcBits   = 7;
	localparam int PrioBits  = 3;
	localparam int RowSrcs   = 8;
	localparam int NumRows   = 16;
	localparam int RowBits   = RowSrcs * PrioBits;
	localparam int VecBits   = 128;

	localparam logic [1:0] CMD_READ    = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_REQUEST = 2'd2;

	localparam logic [20:0] ENABLE_BASE  = 21'h002000;
	localparam logic [25:0] CONTEXT_BASE = 26'h0200000;
	localparam logic [11:0] REG_THRESH   = 12'h000;
	localparam logic [11:0] REG_CLAIM    = 12'h004;
	localparam logic [4:0]  SCAN_LAST    = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PRIO_WB,
		ST_SCAN1,
		ST_CLAIM,
		ST_SCAN2,
		ST_OUT
	} pic_state_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic prio_wb;
		logic scan;
		logic claim;
		logic load_out;
	} pic_cmd_t;

	typedef struct packed {
		logic is_prio;
		logic is_claim;
		logic scan_done;
		logic out_free;
	} pic_status_t;

endpackage

// File: src/pic_ctrl.sv
// Sequencing state machine of the interrupt controller.
// Depends on pic_pkg; drives the datapath through pic_cmd_t.
module pic_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pic_pkg::pic_status_t status,
	output pic_pkg::pic_cmd_t    cmd
);
	import pic_pkg::*;

	pic_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (status.is_prio) state_d = ST_PRIO_WB;
				else if (status.is_claim) state_d = ST_SCAN1;
				else state_d = ST_SCAN2;
			end
			ST_PRIO_WB: state_d = ST_SCAN2;
			ST_SCAN1: begin
				if (status.scan_done) state_d = ST_CLAIM;
			end
			ST_CLAIM: state_d = ST_SCAN2;
			ST_SCAN2: begin
				if (status.scan_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load_in = in_valid;
			end
			ST_EXEC:    cmd.exec = 1'b1;
			ST_PRIO_WB: cmd.prio_wb = 1'b1;
			ST_SCAN1:   cmd.scan = 1'b1;
			ST_CLAIM:   cmd.claim = 1'b1;
			ST_SCAN2:   cmd.scan = 1'b1;
			ST_OUT:     cmd.load_out = status.out_free;
			default:    cmd = '0;
		endcase
	end

endmodule

// File: src/pic_dp.sv
// Register file, priority memory, claim search and result register.
// Depends on pic_pkg; controlled by pic_ctrl.
module pic_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pic_pkg::pic_cmd_t    cmd,
	output pic_pkg::pic_status_t status,
	input  logic [1:0]           command,
	input  logic [25:0]          address,
	input  logic [31:0]          write_data,
	input  logic [6:0]           source_id,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [31:0]          read_data,
	output logic [1:0]           context_irq
);
	import pic_pkg::*;

	logic [1:0]  cmd_q;
	logic [25:0] addr_q;
	logic [31:0] data_q;
	logic [6:0]  src_q;

	logic [VecBits-1:0] pend_q, insvc_q;
	logic [VecBits-1:0] en_q [NumCtx];
	logic [PrioBits-1:0] thr_q [NumCtx];
	logic [SrcBits-1:0] best_id_q [NumCtx];
	logic [PrioBits-1:0] best_p_q [NumCtx];
	logic [31:0] rd_q;
	logic [4:0]  cnt_q;

	logic [RowBits-1:0] prio_mem [NumRows];
	logic [NumRows-1:0] row_vld_q;
	logic [RowBits-1:0] mem_rd_s1;
	logic               mem_vld_s1;

	logic        out_valid_q;
	logic [31:0] out_rd_q;
	logic [1:0]  out_irq_q;

	logic        aligned, prio_hit, pend_hit, en_hit, ctx_hit;
	logic [20:0] en_off;
	logic [25:0] ctx_off;
	logic        en_ctx, ctx_sel;
	logic [1:0]  en_word, pend_word;
	logic [6:0]  prio_id;
	logic [3:0]  rd_row, scan_row;
	logic        mem_we;
	logic [RowBits-1:0] row_base, row_wdata;
	logic [31:0] en_mask;
	logic        cpl_ok;
	logic [SrcBits-1:0] nb_id [NumCtx];
	logic [PrioBits-1:0] nb_p [NumCtx];

	assign aligned   = (addr_q[1:0] == 2'b00);
	assign prio_id   = addr_q[8:2];
	assign prio_hit  = aligned && (addr_q[25:9] == '0) && (prio_id != '0);
	assign pend_hit  = aligned && (addr_q[25:13] == '0) && addr_q[12] && (addr_q[11:4] == '0);
	assign pend_word = addr_q[3:2];
	assign en_off    = addr_q[20:0] - ENABLE_BASE;
	assign en_hit    = aligned && (addr_q[25:21] == '0) && (addr_q[20:13] != '0)
		&& (en_off[20:8] == '0) && (en_off[6:4] == '0);
	assign en_ctx    = en_off[7];
	assign en_word   = en_off[3:2];
	assign ctx_off   = addr_q - CONTEXT_BASE;
	assign ctx_hit   = aligned && (addr_q[25:21] != '0) && (ctx_off[25:13] == '0);
	assign ctx_sel   = ctx_off[12];
	assign en_mask   = (en_word == 2'd0) ? 32'hFFFF_FFFE : 32'hFFFF_FFFF;
	assign cpl_ok    = (data_q[31:7] == '0) && (data_q[6:0] != '0)
		&& en_q[ctx_sel][data_q[6:0]];

	assign status.is_prio   = prio_hit && (cmd_q == CMD_READ || cmd_q == CMD_WRITE);
	assign status.is_claim  = ctx_hit && (cmd_q == CMD_READ) && (addr_q[11:0] == REG_CLAIM);
	assign status.scan_done = (cnt_q == SCAN_LAST);
	assign status.out_free  = !out_valid_q || !out_stall;

	assign rd_row    = cmd.scan ? cnt_q[3:0] : prio_id[6:3];
	assign scan_row  = cnt_q[3:0] - 4'd1;
	assign row_base  = mem_vld_s1 ? mem_rd_s1 : '0;
	assign mem_we    = cmd.prio_wb && (cmd_q == CMD_WRITE);

	always_comb begin
		row_wdata = row_base;
		row_wdata[prio_id[2:0]*PrioBits +: PrioBits] = data_q[PrioBits-1:0];
	end

	always_comb begin
		logic [SrcBits-1:0] id;
		logic [PrioBits-1:0] p;
		for (int c = 0; c < NumCtx; c++) begin
			nb_id[c] = best_id_q[c];
			nb_p[c]  = best_p_q[c];
			for (int k = 0; k < RowSrcs; k++) begin
				id = {scan_row, k[2:0]};
				p  = row_base[k*PrioBits +: PrioBits];
				if (pend_q[id] && !insvc_q[id] && en_q[c][id] && (p > nb_p[c])) begin
					nb_id[c] = id;
					nb_p[c]  = p;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) prio_mem[prio_id[6:3]] <= row_wdata;
		mem_rd_s1 <= prio_mem[rd_row];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q  <= command;
			addr_q <= address;
			data_q <= write_data;
			src_q  <= source_id;
		end
		if (cmd.scan) begin
			for (int c = 0; c < NumCtx; c++) begin
				if (cnt_q == '0) begin
					best_id_q[c] <= '0;
					best_p_q[c]  <= thr_q[c];
				end else begin
					best_id_q[c] <= nb_id[c];
					best_p_q[c]  <= nb_p[c];
				end
			end
		end
		if (cmd.load_out) begin
			out_rd_q <= rd_q;
			for (int c = 0; c < NumCtx; c++) out_irq_q[c] <= (best_id_q[c] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			insvc_q     <= '0;
			for (int c = 0; c < NumCtx; c++) begin
				en_q[c]  <= '0;
				thr_q[c] <= '0;
			end
			row_vld_q   <= '0;
			mem_vld_s1  <= 1'b0;
			cnt_q       <= '0;
			rd_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			mem_vld_s1 <= row_vld_q[rd_row];
			cnt_q <= (cmd.scan && !status.scan_done) ? cnt_q + 5'd1 : '0;
			if (cmd.load_in) rd_q <= '0;
			if (cmd.exec) begin
				case (cmd_q)
					CMD_REQUEST: begin
						if (src_q != '0) pend_q[src_q] <= 1'b1;
					end
					CMD_WRITE: begin
						if (en_hit) en_q[en_ctx][en_word*32 +: 32] <= data_q & en_mask;
						if (ctx_hit && addr_q[11:0] == REG_THRESH)
							thr_q[ctx_sel] <= data_q[PrioBits-1:0];
						if (ctx_hit && addr_q[11:0] == REG_CLAIM && cpl_ok)
							insvc_q[data_q[6:0]] <= 1'b0;
					end
					CMD_READ: begin
						if (pend_hit) rd_q <= pend_q[pend_word*32 +: 32];
						if (en_hit) rd_q <= en_q[en_ctx][en_word*32 +: 32];
						if (ctx_hit && addr_q[11:0] == REG_THRESH)
							rd_q <= {29'd0, thr_q[ctx_sel]};
					end
					default: rd_q <= '0;
				endcase
			end
			if (cmd.prio_wb) begin
				if (mem_we) row_vld_q[prio_id[6:3]] <= 1'b1;
				else rd_q <= {29'd0, row_base[prio_id[2:0]*PrioBits +: PrioBits]};
			end
			if (cmd.claim) begin
				rd_q <= {25'd0, best_id_q[ctx_sel]};
				if (best_id_q[ctx_sel] != '0) begin
					pend_q[best_id_q[ctx_sel]]  <= 1'b0;
					insvc_q[best_id_q[ctx_sel]] <= 1'b1;
				end
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = out_rd_q;
	assign context_irq = out_irq_q;

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SCAN_LAST) else $error("scan counter overrun");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall)) else $error("result overwritten");
	a_src0_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!pend_q[0] && !en_q[0][0]) else $error("source zero marked");
`endif

endmodule

// File: src/platform_interrupt_controller.sv
// Top level of the platform interrupt controller: joins pic_ctrl and pic_dp.
// Every beat ends with a claim search for the interrupt lines; a claim read runs
// one before the claim too. Each claim search scans 16 memory rows of 8 sources.
// One beat is in flight at a time; the next is taken once the result is registered.
// arst_n clears all priorities, pending, in-service, enable and threshold state.
module platform_interrupt_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [25:0] address,
	input  logic [31:0] write_data,
	input  logic [6:0]  source_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic [1:0]  context_irq
);
	import pic_pkg::*;

	pic_cmd_t    cmd;
	pic_status_t status;

	pic_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pic_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.command     (command),
		.address     (address),
		.write_data  (write_data),
		.source_id   (source_id),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.context_irq (context_irq)
	);

endmodule

// File: dv/tb.sv
// Self-checking testbench for the platform interrupt controller register map.
// Predicts read data and interrupt lines per beat; depends on pic_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
	import pic_pkg::*;

	localparam int NSRC = 127;
	localparam int NWORDS = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  command = '0;
	logic [25:0] address = '0;
	logic [31:0] write_data = '0;
	logic [6:0]  source_id = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_data;
	logic [1:0]  context_irq;

	platform_interrupt_controller DUT (.*);

	always #1 clk = ~clk;

	logic [2:0]   prio_q [0:NSRC];
	logic [127:0] pend_q, serv_q;
	logic [127:0] en_q [0:NumCtx-1];
	logic [2:0]   thr_q [0:NumCtx-1];

	logic [31:0] exp_rdata [$];
	logic [1:0]  exp_irq [$];

	int errors = 0;
	int sent = 0;
	int checked = 0;
	int claims_hit = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;

	function automatic logic [6:0] top_source(int c);
		logic [6:0] best;
		logic [2:0] bp;
		best = '0;
		bp = thr_q[c];
		for (int id = 1; id <= NSRC; id++)
			if (pend_q[id] && !serv_q[id] && en_q[c][id] && prio_q[id] > bp) begin
				best = id[6:0];
				bp = prio_q[id];
			end
		return best;
	endfunction

	function automatic logic [31:0] access_model(bit wr, logic [25:0] a, logic [31:0] d);
		int id, w, c, r, off;
		logic [6:0] s;
		if (a[1:0] != 0) return 0;
		if (a < 26'h1000) begin
			id = a >> 2;
			if (id == 0 || id > NSRC) return 0;
			if (wr) prio_q[id] = d[2:0];
			return wr ? 0 : {29'b0, prio_q[id]};
		end
		if (a < 26'h2000) begin
			w = (a - 26'h1000) >> 2;
			if (w >= NWORDS || wr) return 0;
			return pend_q[w*32 +: 32];
		end
		if (a < CONTEXT_BASE) begin
			off = a - 26'h2000;
			c = off / 'h80;
			w = (off % 'h80) >> 2;
			if (c >= NumCtx || w >= NWORDS) return 0;
			if (wr) begin
				en_q[c][w*32 +: 32] = d;
				en_q[c][0] = 1'b0;
				return 0;
			end
			return en_q[c][w*32 +: 32];
		end
		off = a - CONTEXT_BASE;
		c = off >> 12;
		r = off & 'hfff;
		if (c >= NumCtx) return 0;
		if (r == REG_THRESH) begin
			if (wr) thr_q[c] = d[2:0];
			return wr ? 0 : {29'b0, thr_q[c]};
		end
		if (r == REG_CLAIM) begin
			if (wr) begin
				if (d >= 1 && d <= NSRC && en_q[c][d[6:0]]) serv_q[d[6:0]] = 1'b0;
				return 0;
			end
			s = top_source(c);
			if (s != 0) begin
				pend_q[s] = 1'b0;
				serv_q[s] = 1'b1;
				claims_hit++;
			end
			return {25'b0, s};
		end
		return 0;
	endfunction

	task automatic predict_beat(logic [1:0] cmd, logic [25:0] a, logic [31:0] d,
			logic [6:0] src);
		logic [31:0] rd;
		logic [1:0] irq;
		rd = '0;
		irq = '0;
		if (cmd == CMD_READ) rd = access_model(1'b0, a, 0);
		else if (cmd == CMD_WRITE) void'(access_model(1'b1, a, d));
		else if (cmd == CMD_REQUEST && src != 0) pend_q[src] = 1'b1;
		for (int c = 0; c < NumCtx; c++) irq[c] = top_source(c) != 0;
		exp_rdata.push_back(rd);
		exp_irq.push_back(irq);
	endtask

	task automatic send_beat(logic [1:0] cmd, logic [25:0] a, logic [31:0] d,
			logic [6:0] src);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		address <= a;
		write_data <= d;
		source_id <= src;
		predict_beat(cmd, a, d, src);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (exp_rdata.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				if (read_data !== exp_rdata[0]) begin
					$error("read_data: expected %h, got %h", exp_rdata[0], read_data);
					errors++;
				end
				if (context_irq !== exp_irq[0]) begin
					$error("context_irq: expected %b, got %b", exp_irq[0], context_irq);
					errors++;
				end
				void'(exp_rdata.pop_front());
				void'(exp_irq.pop_front());
				checked++;
			end
		end
	end

	function automatic logic [25:0] prio_addr(int id);
		return 26'(id * 4);
	endfunction

	function automatic logic [25:0] enable_addr(int c, int w);
		return 26'(26'h2000 + c * 'h80 + w * 4);
	endfunction

	function automatic logic [25:0] ctx_addr(int c, logic [11:0] r);
		return 26'(CONTEXT_BASE + c * 'h1000 + r);
	endfunction

	task automatic drain_results();
		in_valid <= 1'b0;
		while (exp_rdata.size() != 0) @(posedge clk);
	endtask

	task automatic test_register_map();
		send_beat(CMD_WRITE, prio_addr(1), 32'hffff_ffff, 0);
		send_beat(CMD_READ, prio_addr(1), 0, 0);
		send_beat(CMD_WRITE, prio_addr(0), 32'h7, 0);
		send_beat(CMD_READ, prio_addr(0), 0, 0);
		send_beat(CMD_WRITE, prio_addr(NSRC), 32'h5, 0);
		send_beat(CMD_READ, prio_addr(NSRC), 0, 0);
		send_beat(CMD_WRITE, enable_addr(0, 0), 32'hffff_ffff, 0);
		send_beat(CMD_READ, enable_addr(0, 0), 0, 0);
		send_beat(CMD_WRITE, enable_addr(1, 3), 32'hffff_ffff, 0);
		send_beat(CMD_READ, enable_addr(1, 3), 0, 0);
		send_beat(CMD_WRITE, ctx_addr(0, REG_THRESH), 32'hffff_fff9, 0);
		send_beat(CMD_READ, ctx_addr(0, REG_THRESH), 0, 0);
		send_beat(CMD_WRITE, 26'h1000, 32'hffff_ffff, 0);
		send_beat(CMD_READ, 26'h3ff_fffe, 0, 0);
		send_beat(2'd3, 26'h3ff_ffff, 32'hffff_ffff, 7'h7f);
		send_beat(CMD_READ, ctx_addr(2, REG_THRESH), 0, 0);
	endtask

	task automatic test_claim_complete();
		send_beat(CMD_WRITE, ctx_addr(0, REG_THRESH), 0, 0);
		send_beat(CMD_REQUEST, 0, 0, 0);
		send_beat(CMD_REQUEST, 0, 0, 1);
		send_beat(CMD_REQUEST, 0, 0, 7'd127);
		send_beat(CMD_READ, 26'h100c, 0, 0);
		send_beat(CMD_READ, ctx_addr(0, REG_CLAIM), 0, 0);
		send_beat(CMD_REQUEST, 0, 0, 1);
		send_beat(CMD_READ, ctx_addr(0, REG_CLAIM), 0, 0);
		send_beat(CMD_WRITE, ctx_addr(1, REG_CLAIM), 1, 0);
		send_beat(CMD_WRITE, ctx_addr(0, REG_CLAIM), 0, 0);
		send_beat(CMD_WRITE, ctx_addr(0, REG_CLAIM), 1, 0);
		send_beat(CMD_READ, ctx_addr(0, REG_CLAIM), 0, 0);
		send_beat(CMD_READ, ctx_addr(1, REG_CLAIM), 0, 0);
		drain_results();
	endtask

	function automatic logic [25:0] random_addr();
		case ($urandom_range(9))
			0, 1: return 26'($urandom_range(NSRC + 1) * 4);
			2: return 26'(26'h1000 + $urandom_range(4) * 4);
			3, 4: return enable_addr($urandom_range(2), $urandom_range(4));
			5: return ctx_addr($urandom_range(2), REG_THRESH);
			6, 7: return ctx_addr($urandom_range(2), REG_CLAIM);
			8: return 26'($urandom());
			default: return ctx_addr($urandom_range(1), 12'($urandom_range(12'hfff)));
		endcase
	endfunction

	task automatic random_beats(int count);
		logic [1:0] cmd;
		logic [25:0] a;
		logic [31:0] d;
		for (int i = 0; i < count; i++) begin
			cmd = $urandom_range(9) < 4 ? CMD_REQUEST : $urandom_range(9) == 0 ? 2'd3 :
				$urandom_range(1) ? CMD_READ : CMD_WRITE;
			a = random_addr();
			d = $urandom_range(3) == 0 ? $urandom() :
				$urandom_range(3) == 0 ? 32'($urandom_range(NSRC + 1)) : 32'($urandom_range(7));
			if (cmd == CMD_WRITE && a >= 26'h2000 && a < CONTEXT_BASE && $urandom_range(1))
				d = $urandom() | $urandom();
			send_beat(cmd, a, d, 7'($urandom()));
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = 400;
		random_beats(20);
		drain_results();
		random_beats(20);
		drain_results();
	endtask

	initial begin
		for (int i = 0; i <= NSRC; i++) prio_q[i] = 0;
		pend_q = 0;
		serv_q = 0;
		for (int c = 0; c < NumCtx; c++) begin
			en_q[c] = 0;
			thr_q[c] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_map();
		test_claim_complete();
		send_idle_pct = 12;
		recv_idle_pct = 67;
		random_beats(160);
		send_idle_pct = 67;
		recv_idle_pct = 12;
		random_beats(160);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_beats(120);
		test_backpressure();
		drain_results();
		repeat (60) @(posedge clk);
		$display("tb: %0d beats sent, %0d results checked, %0d claims returned a source",
			sent, checked, claims_hit);
		if (errors == 0 && exp_rdata.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule

// File: filelist.f
src/pic_pkg.sv
src/pic_ctrl.sv
src/pic_dp.sv
src/platform_interrupt_controller.sv
dv/tb.sv
